FILE: design/mtwd_pkg.sv
// ----------------------------------------------------------------------------
// Multi-task watchdog monitor package
// Shared widths, action codes, status codes, config indices, sequencer states and the token type.
// ----------------------------------------------------------------------------
`default_nettype none
package mtwd_pkg;
  localparam int SLOTS_DEF    = 16;
  localparam int KEY_BITS_DEF = 8;
  localparam int KEY_W        = 8;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 32;
  localparam int STREAK_W     = 8;
  localparam int TOUT_W       = 12;
  localparam int USED_W       = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;
  localparam logic [STREAK_W-1:0] STREAK_LIMIT = 8'd3;
  localparam logic [STREAK_W-1:0] STREAK_MAX   = 8'd255;
  localparam logic [9:0]          MS_PER_SEC   = 10'd1000;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_FEED     = 3'd1,
    ACT_CHECK    = 3'd2,
    ACT_RECOVER  = 3'd3,
    ACT_QUERY    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_DISABLED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED = 2'd0,
    CFG_PAUSED  = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // Token passed along the cell chain; one cell acts on it each cycle.
  typedef struct packed {
    logic                 active;
    logic [2:0]           action;
    logic [KEY_W-1:0]     key;
    logic [TIME_W-1:0]    now;
    logic [TIME_W-1:0]    limit;
    logic                 feed_ok;
    logic                 hit;
    logic                 stop;
    logic                 streak_nz;
    logic [CNT_W-1:0]     missed;
    logic                 alive;
  } token_t;
endpackage
`default_nettype wire

FILE: design/mtwd_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries valid, ready and a packed payload between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface mtwd_if #(parameter int W = 1) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/multi_task_watchdog_monitor_top.sv
// ----------------------------------------------------------------------------
// Multi-task watchdog monitor, top level
// Task table as a row of slot cells with a sequencer and global counters.
// ----------------------------------------------------------------------------
// From acceptance to result, the request token walks the row of slot
// cells one cell per cycle, then the global counters update and the
// result is registered. One transaction is in flight at a time; the
// input is taken again once the result is taken.
`default_nettype none
module multi_task_watchdog_monitor_top #(
  parameter int SLOTS    = mtwd_pkg::SLOTS_DEF,
  parameter int KEY_BITS = mtwd_pkg::KEY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mtwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mtwd_pkg::CFG_DATA_W-1:0] cfg_data,
  mtwd_if.sink                               in_ch,
  mtwd_if.source                             out_ch
);
  import mtwd_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  logic              enabled;
  logic              feeds_paused;
  logic [TOUT_W-1:0] timeout_sec;
  state_t            state, state_next;
  logic [CW-1:0]     step;
  logic [CW-1:0]     slot_used;
  logic [CNT_W-1:0]  feed_total;
  logic [CNT_W-1:0]  recovery_total;
  logic              alert_flag;
  token_t            head;
  token_t            chain [SLOTS+1];
  logic [SLOTS-1:0]  load;
  logic [2:0]        in_action;
  logic [KEY_W-1:0]  in_key;
  logic [TIME_W-1:0] in_now;
  logic [TIME_W-1:0] limit;
  logic [21:0]       tms;
  token_t            tail;
  logic              reg_new;
  logic              feed_hit;
  logic [1:0]        status;
  logic              kick;
  logic              alive;
  logic [CNT_W-1:0]  missed;
  logic              refused;

  assign in_action = in_ch.data[KEY_W+TIME_W +: 3];
  assign in_key    = KEY_W'(in_ch.data[TIME_W +: KEY_W] & KEY_W'((1 << KEY_BITS) - 1));
  assign in_now    = in_ch.data[TIME_W-1:0];
  assign tms       = 22'(timeout_sec) * 22'(MS_PER_SEC);
  assign limit     = TIME_W'(tms >> 1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b1;
      feeds_paused <= 1'b0;
      timeout_sec  <= TOUT_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED: enabled      <= cfg_data[0];
        CFG_PAUSED:  feeds_paused <= cfg_data[0];
        CFG_TIMEOUT: timeout_sec  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Token launched into the row. A check while disabled starts out stopped,
  // so that no slot is touched.
  always_ff @(posedge clk) begin
    if (rst) begin
      head.active <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      head.active    <= 1'b1;
      head.action    <= in_action;
      head.key       <= in_key;
      head.now       <= in_now;
      head.limit     <= limit;
      head.feed_ok   <= enabled && !feeds_paused;
      head.hit       <= 1'b0;
      head.stop      <= (in_action == ACT_CHECK) && !enabled;
      head.streak_nz <= 1'b0;
      head.missed    <= '0;
      head.alive     <= 1'b0;
    end
  end

  assign chain[0] = head;

  // Row of slot cells; cell i acts in scan step i.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign load[i] = (state == S_SCAN) && (step == CW'(i));
    mtwd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .occupied  (CW'(i) < slot_used),
      .load      (load[i]),
      .write_new (load[i] && (head.action == ACT_REGISTER) && (slot_used == CW'(i))
                  && !chain[i].hit),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1])
    );
  end

  // A cell passes the token on only when loaded; the last copy is the result.
  assign tail = chain[SLOTS];

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) step <= step + 1'b1;
      else                 step <= '0;
    end
  end

  always_comb begin
    state_next   = state;
    in_ch.ready  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ch.ready = !out_ch.valid;
        if (in_ch.valid && in_ch.ready) state_next = S_SCAN;
      end
      S_SCAN:  if (step == CW'(SLOTS - 1)) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Chain is laid out so cell i reads chain[i]; token advances via each
  // cell's register, so cell i sees the token at step i.
  assign reg_new  = (tail.action == ACT_REGISTER) && !tail.hit
                    && (slot_used < CW'(SLOTS));
  assign feed_hit = (tail.action == ACT_FEED) && tail.hit;

  always_comb begin
    status  = ST_OK;
    kick    = 1'b0;
    alive   = 1'b0;
    missed  = '0;
    refused = 1'b0;
    case (tail.action)
      ACT_REGISTER: refused = (slot_used >= CW'(SLOTS));
      ACT_FEED: begin
        refused = !tail.hit;
        kick    = tail.hit;
      end
      ACT_CHECK: begin
        if (!enabled)      status = ST_DISABLED;
        else if (tail.stop) status = ST_TIMEOUT;
      end
      ACT_RECOVER: kick = 1'b1;
      ACT_QUERY: begin
        refused = !tail.hit;
        missed  = tail.hit ? tail.missed : '0;
        alive   = !tail.hit || !enabled || tail.alive;
      end
      default: begin
      end
    endcase
  end

  // Global counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used      <= '0;
      feed_total     <= '0;
      recovery_total <= '0;
      alert_flag     <= 1'b0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (state == S_DONE) begin
        logic              al;
        logic [CNT_W-1:0]  rc;
        logic [CNT_W-1:0]  fc;
        logic [CW-1:0]     su;
        al = alert_flag;
        rc = recovery_total;
        fc = feed_total;
        su = slot_used;
        if (reg_new) su = su + 1'b1;
        if (feed_hit) begin
          fc = fc + 1'b1;
          if (tail.streak_nz) begin
            rc = rc + 1'b1;
            al = 1'b0;
          end
        end
        if (tail.action == ACT_CHECK && enabled && tail.stop) al = 1'b1;
        if (tail.action == ACT_RECOVER) rc = rc + 1'b1;
        slot_used      <= su;
        feed_total     <= fc;
        recovery_total <= rc;
        alert_flag     <= al;
        out_ch.valid   <= 1'b1;
        out_ch.data    <= {status, kick, al, alive, missed, refused, fc, rc, USED_W'(su)};
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/mtwd_cell.sv
// ----------------------------------------------------------------------------
// Watchdog slot cell
// Holds one task slot and acts on the token as it passes through.
// ----------------------------------------------------------------------------
`default_nettype none
module mtwd_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            occupied,
  input  wire logic            load,
  input  wire logic            write_new,
  input  wire mtwd_pkg::token_t tok_in,
  output mtwd_pkg::token_t      tok_out
);
  import mtwd_pkg::*;

  logic [KEY_W-1:0]    key;
  logic [TIME_W-1:0]   last_feed;
  logic [CNT_W-1:0]    feed_count;
  logic [CNT_W-1:0]    missed_total;
  logic                fed_mark;
  logic [STREAK_W-1:0] streak;
  logic [TIME_W-1:0]   age;
  logic [STREAK_W-1:0] streak_inc;
  logic                act;
  token_t              tok_next;

  assign act        = load && tok_in.active && !tok_in.stop && !tok_in.hit && occupied;
  assign age        = tok_in.now - last_feed;
  assign streak_inc = (streak < STREAK_MAX) ? streak + 1'b1 : streak;

  // Token update for this slot.
  always_comb begin
    tok_next = tok_in;
    if (act) begin
      case (tok_in.action)
        ACT_FEED: begin
          if (tok_in.feed_ok && key == tok_in.key) begin
            tok_next.hit       = 1'b1;
            tok_next.streak_nz = (streak != '0);
          end
        end
        ACT_QUERY, ACT_REGISTER: begin
          if (key == tok_in.key) begin
            tok_next.hit    = 1'b1;
            tok_next.missed = missed_total;
            tok_next.alive  = (age < tok_in.limit);
          end
        end
        ACT_CHECK: begin
          if (age > tok_in.limit && !fed_mark && streak_inc > STREAK_LIMIT)
            tok_next.stop = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Slot storage; only written slots are ever read.
  always_ff @(posedge clk) begin
    if (write_new) begin
      key          <= tok_in.key;
      last_feed    <= tok_in.now;
      feed_count   <= '0;
      missed_total <= '0;
      fed_mark     <= 1'b0;
      streak       <= '0;
    end else if (act) begin
      case (tok_in.action)
        ACT_FEED: begin
          if (tok_in.feed_ok && key == tok_in.key) begin
            last_feed  <= tok_in.now;
            feed_count <= feed_count + 1'b1;
            fed_mark   <= 1'b1;
            streak     <= '0;
          end
        end
        ACT_CHECK: begin
          if (age > tok_in.limit && !fed_mark) begin
            streak       <= streak_inc;
            missed_total <= missed_total + 1'b1;
            if (!(streak_inc > STREAK_LIMIT)) fed_mark <= 1'b0;
          end else begin
            fed_mark <= 1'b0;
          end
        end
        ACT_RECOVER: begin
          streak    <= '0;
          last_feed <= tok_in.now;
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline register towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else if (load) begin
      tok_out <= tok_next;
    end
  end
endmodule
`default_nettype wire

FILE: design/mtwd_checker.sv
// ----------------------------------------------------------------------------
// Watchdog monitor port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module mtwd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [106:0] out_data
);
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No new transaction is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // A check never reports timeout without the alert set.
  a_alert: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[106:105] == 2'd1 |-> out_data[103])
    else $error("timeout without alert");

  // Occupied slot count never exceeds sixteen.
  a_used: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[4:0] <= 5'd16)
    else $error("slot count out of range");
endmodule

bind multi_task_watchdog_monitor_top mtwd_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data (out_ch.data)
);
`default_nettype wire

FILE: bench/tb_multi_task_watchdog_monitor_top.sv
// ----------------------------------------------------------------------------
// Multi-task watchdog monitor testbench
// Drives register, feed, check, recover, query and undefined transactions
// through the valid/ready channels under random idling on both sides and
// several register settings. A scoreboard predicts each result and compares
// it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_multi_task_watchdog_monitor_top;
  import mtwd_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  key;
    logic [31:0] now;
  } watch_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        kick;
    logic        alert;
    logic        alive;
    logic [31:0] missed;
    logic        refused;
    logic [31:0] feeds;
    logic [31:0] recov;
    logic [4:0]  used;
  } watch_rsp_t;

  // Predicts the monitor's answers and holds them until they arrive.
  class watchdog_scoreboard;
    bit [7:0]    key_tab[NSLOT];
    bit [31:0]   last_tab[NSLOT];
    bit [31:0]   missed_tab[NSLOT];
    bit          fed_tab[NSLOT];
    bit [7:0]    streak_tab[NSLOT];
    int unsigned used_cnt;
    bit [31:0]   feed_sum;
    bit [31:0]   recov_sum;
    bit          alert;
    bit          en;
    bit          paused;
    bit [11:0]   tout;
    watch_rsp_t  expected_q[$];
    int unsigned mismatches;

    function new();
      used_cnt = 0; feed_sum = 0; recov_sum = 0; alert = 0;
      en = 1; paused = 0; tout = 12'd10; mismatches = 0;
    endfunction

    function bit [31:0] stale_limit();
      return (32'(tout) * 32'd1000) >> 1;
    endfunction

    function int slot_of(bit [7:0] k);
      for (int i = 0; i < used_cnt; i++)
        if (key_tab[i] == k) return i;
      return -1;
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Works out the result of one accepted transaction.
    function void note_input(watch_req_t r);
      watch_rsp_t e;
      int s;
      bit [31:0] lim;
      lim = stale_limit();
      e = '0;
      e.status = ST_OK;
      case (r.action)
        ACT_REGISTER: begin
          if (used_cnt >= NSLOT) e.refused = 1;
          else if (slot_of(r.key) < 0) begin
            key_tab[used_cnt] = r.key;
            last_tab[used_cnt] = r.now;
            missed_tab[used_cnt] = 0;
            fed_tab[used_cnt] = 0;
            streak_tab[used_cnt] = 0;
            used_cnt++;
          end
        end
        ACT_FEED: begin
          s = (en && !paused) ? slot_of(r.key) : -1;
          if (s < 0) e.refused = 1;
          else begin
            last_tab[s] = r.now;
            fed_tab[s] = 1;
            feed_sum++;
            if (streak_tab[s] != 0) begin
              recov_sum++;
              alert = 0;
            end
            streak_tab[s] = 0;
            e.kick = 1;
          end
        end
        ACT_CHECK: begin
          if (!en) e.status = ST_DISABLED;
          else begin
            for (int i = 0; i < used_cnt; i++) begin
              if (32'(r.now - last_tab[i]) > lim && !fed_tab[i]) begin
                if (streak_tab[i] != 8'd255) streak_tab[i]++;
                missed_tab[i]++;
                if (streak_tab[i] > 8'd3) begin
                  alert = 1;
                  e.status = ST_TIMEOUT;
                  break;
                end
              end
              fed_tab[i] = 0;
            end
          end
        end
        ACT_RECOVER: begin
          for (int i = 0; i < used_cnt; i++) begin
            streak_tab[i] = 0;
            last_tab[i] = r.now;
          end
          e.kick = 1;
          recov_sum++;
        end
        ACT_QUERY: begin
          s = slot_of(r.key);
          if (s < 0) begin
            e.refused = 1;
            e.alive = 1;
          end else begin
            e.missed = missed_tab[s];
            e.alive = !en || (32'(r.now - last_tab[s]) < lim);
          end
        end
        default: ;
      endcase
      e.alert = alert;
      e.feeds = feed_sum;
      e.recov = recov_sum;
      e.used = 5'(used_cnt);
      expected_q.push_back(e);
    endfunction

    // Compares one result with the oldest expectation.
    task check_result(watch_rsp_t g);
      watch_rsp_t e;
      if (expected_q.size() == 0) begin
        report("result with no expectation waiting");
        return;
      end
      e = expected_q.pop_front();
      if (g.status !== e.status)
        report($sformatf("check_status %0d, expected %0d", g.status, e.status));
      if (g.kick !== e.kick) report($sformatf("kick %0b, expected %0b", g.kick, e.kick));
      if (g.alert !== e.alert)
        report($sformatf("alert %0b, expected %0b", g.alert, e.alert));
      if (g.alive !== e.alive)
        report($sformatf("task_alive %0b, expected %0b", g.alive, e.alive));
      if (g.missed !== e.missed)
        report($sformatf("task_missed %0d, expected %0d", g.missed, e.missed));
      if (g.refused !== e.refused)
        report($sformatf("refused %0b, expected %0b", g.refused, e.refused));
      if (g.feeds !== e.feeds)
        report($sformatf("total_feeds %0d, expected %0d", g.feeds, e.feeds));
      if (g.recov !== e.recov)
        report($sformatf("recoveries %0d, expected %0d", g.recov, e.recov));
      if (g.used !== e.used)
        report($sformatf("tasks_registered %0d, expected %0d", g.used, e.used));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    quiet;
  int                    stall_left;
  bit [31:0]             clock_ms;
  bit [7:0]              key_pool[24];
  watchdog_scoreboard    sb;

  mtwd_if #(.W($bits(watch_req_t))) in_ch ();
  mtwd_if #(.W($bits(watch_rsp_t))) out_ch ();

  multi_task_watchdog_monitor_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall bursts, none once the run turns quiet.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(watch_rsp_t'(out_ch.data));

  // Offers one transaction, with a random gap in front, and waits for it
  // to be taken.
  task send_item(logic [2:0] act, logic [7:0] k, logic [31:0] t);
    watch_req_t r;
    r = '{action: act, key: k, now: t};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(r);
  endtask

  // Lets the block drain before the registers change.
  task drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (NSLOT + 4) @(posedge clk);
  endtask

  // Presents one register write for a single edge; the caller drops the
  // write enable after the last one.
  task write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_ENABLED: sb.en = v[0];
      CFG_PAUSED:  sb.paused = v[0];
      default:     sb.tout = v[11:0];
    endcase
  endtask

  task set_regs(bit e, bit p, logic [11:0] t);
    drain();
    write_reg(CFG_ENABLED, CFG_DATA_W'(e));
    write_reg(CFG_PAUSED, CFG_DATA_W'(p));
    write_reg(CFG_TIMEOUT, t);
    cfg_we <= 1'b0;
  endtask

  // Mostly a running clock with steps around the staleness limit, at
  // times a jump anywhere.
  function bit [31:0] next_ms();
    bit [31:0] lim;
    lim = sb.stale_limit();
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 3 * lim);
    return clock_ms;
  endfunction

  task random_items(int n);
    int w;
    logic [2:0] act;
    logic [7:0] k;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 14) act = ACT_REGISTER;
      else if (w < 40) act = ACT_FEED;
      else if (w < 70) act = ACT_CHECK;
      else if (w < 75) act = ACT_RECOVER;
      else if (w < 95) act = ACT_QUERY;
      else act = 3'($urandom_range(5, 7));
      k = ($urandom_range(0, 9) == 0) ? 8'($urandom) : key_pool[$urandom_range(0, 23)];
      send_item(act, k, next_ms());
    end
  endtask

  initial begin
    bit [11:0] t_set[8];
    bit        e_set[8];
    bit        p_set[8];
    sb = new();
    quiet = 0;
    clock_ms = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_ENABLED;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.data = '0;
    foreach (key_pool[i]) key_pool[i] = 8'($urandom);
    key_pool[0] = 8'h00;
    key_pool[1] = 8'hFF;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: key extremes, all actions, stale check streak, alert clearing,
    // wrap of time, undefined actions, then disabled and paused behaviour.
    send_item(ACT_REGISTER, 8'h00, 32'd0);
    send_item(ACT_REGISTER, 8'hFF, 32'd100);
    send_item(ACT_REGISTER, 8'hFF, 32'd200);
    send_item(ACT_FEED, 8'hFF, 32'd300);
    send_item(ACT_FEED, 8'h5A, 32'd300);
    send_item(ACT_QUERY, 8'h00, 32'd4999);
    send_item(ACT_QUERY, 8'h5A, 32'd5000);
    for (int i = 1; i <= 5; i++) send_item(ACT_CHECK, 8'h00, 32'(i * 6000));
    send_item(ACT_QUERY, 8'h00, 32'd40000);
    send_item(ACT_FEED, 8'h00, 32'd41000);
    send_item(ACT_RECOVER, 8'h00, 32'hFFFF_FFF0);
    send_item(ACT_CHECK, 8'h00, 32'h0000_2000);
    send_item(3'd5, 8'hAA, 32'hFFFF_FFFF);
    send_item(3'd6, 8'h55, 32'h5555_5555);
    send_item(3'd7, 8'hFF, 32'hAAAA_AAAA);
    set_regs(0, 0, 12'd10);
    send_item(ACT_FEED, 8'h00, 32'd1);
    send_item(ACT_CHECK, 8'h00, 32'd2);
    send_item(ACT_QUERY, 8'hFF, 32'h8000_0000);
    set_regs(1, 1, 12'd10);
    send_item(ACT_FEED, 8'hFF, 32'd3);
    clock_ms = 32'd10;

    // Random phases over several settings, extremes among them.
    e_set = '{1, 1, 0, 1, 1, 1, 0, 1};
    p_set = '{0, 0, 0, 1, 0, 0, 1, 0};
    t_set = '{12'd1, 12'd3600, 12'd2047, 12'd10, 12'($urandom_range(1, 3600)),
              12'd1, 12'd5, 12'd2};
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(e_set[ph], p_set[ph], t_set[ph]);
      if (ph == 7) quiet = 1;
      random_items(92);
    end

    drain();
    repeat (NSLOT + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule

FILE: filelist.f
design/mtwd_pkg.sv
design/mtwd_if.sv
design/mtwd_cell.sv
design/multi_task_watchdog_monitor_top.sv
design/mtwd_checker.sv
bench/tb_multi_task_watchdog_monitor_top.sv
